// File: src/spa_pkg.sv
// Shared types and codes for the SQL partial aggregator.
package spa_pkg;

    // Widths of the item fields
    localparam int VAL_W  = 64;
    localparam int CNT_W  = 32;
    localparam int KIND_W = 3;
    localparam int OP_W   = 2;

    // Aggregate kinds (config register)
    localparam logic [KIND_W-1:0] KIND_COUNT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUM   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_AVG   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MIN   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MAX   = 3'd4;

    // Item operations
    localparam logic [OP_W-1:0] OP_ACC   = 2'd0;
    localparam logic [OP_W-1:0] OP_MERGE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIN   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] item_value;
        logic                    item_null;
        logic [CNT_W-1:0]        partial_count;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic [CNT_W-1:0]        result_count;
        logic                    result_null;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // apply the accepted item to the slot
        logic div_start;  // launch the AVG divide
        logic div_load;   // load the quotient into the output register
    } spa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;   // the presented item is an AVG finalize with a quotient
        logic div_done;   // divider finished this cycle
    } spa_sts_t;

endpackage

// File: src/spa_div.sv
// Iterative signed 64 by unsigned 32 divider, one quotient bit per cycle.
module spa_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [spa_pkg::VAL_W-1:0]    dividend,
    input  logic [spa_pkg::CNT_W-1:0]           divisor,
    output logic                                done,
    output logic signed [spa_pkg::VAL_W-1:0]    quotient
);

    localparam int VW = spa_pkg::VAL_W;
    localparam int CW = spa_pkg::CNT_W;
    localparam int SW = $clog2(VW);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [SW-1:0]   step_reg, step_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic [VW-1:0]   quo_reg, quo_next;
    logic [CW-1:0]   dsr_reg, dsr_next;
    logic            neg_reg, neg_next;

    logic [CW:0]     shifted;
    logic [CW:0]     diff;
    logic            fits;

    // One restoring step: shift in the next dividend bit, try to subtract
    assign shifted = {rem_reg, quo_reg[VW-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = (shifted >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = SW'(VW - 1);
            rem_next  = '0;
            // magnitude of the dividend; the most negative value maps to 2^63
            quo_next  = dividend[VW-1] ? (VW'(0) - VW'(dividend)) : VW'(dividend);
            dsr_next  = divisor;
            neg_next  = dividend[VW-1];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[CW-1:0] : shifted[CW-1:0];
            quo_next = {quo_reg[VW-2:0], fits};
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dsr_reg  <= dsr_next;
        neg_reg  <= neg_next;
    end

    // Truncation toward zero: negate the magnitude quotient when needed
    assign done     = done_reg;
    assign quotient = neg_reg ? signed'(VW'(0) - quo_reg) : signed'(quo_reg);

endmodule

// File: src/spa_datapath.sv
// Aggregate slot state, update logic, AVG divider and output register.
module spa_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [spa_pkg::KIND_W-1:0]    cfg_kind,
    input  spa_pkg::in_item_t             in_item,
    input  spa_pkg::spa_cmd_t             cmd,
    output spa_pkg::spa_sts_t             sts,
    output spa_pkg::out_item_t            out_item
);

    localparam int VW = spa_pkg::VAL_W;
    localparam int CW = spa_pkg::CNT_W;

    logic [spa_pkg::KIND_W-1:0] kind_reg;
    logic signed [VW-1:0]       val_reg, val_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       null_reg, null_next;
    spa_pkg::out_item_t         out_reg, out_next;

    logic signed [VW-1:0]       sum_raw, sum_sat;
    logic [CW:0]                cnt_raw;
    logic [CW-1:0]              cnt_add, cnt_sat;
    logic                       v_lt, v_gt;
    logic                       avg_fin;
    logic                       div_done;
    logic signed [VW-1:0]       div_q;

    // Shared saturating adders for value and count
    assign sum_raw = val_reg + in_item.item_value;
    always_comb
    begin
        sum_sat = sum_raw;
        if ((val_reg[VW-1] == in_item.item_value[VW-1]) && (sum_raw[VW-1] != val_reg[VW-1]))
            sum_sat = val_reg[VW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end

    assign cnt_add = (in_item.op == spa_pkg::OP_MERGE) ? in_item.partial_count : CW'(1);
    assign cnt_raw = {1'b0, cnt_reg} + {1'b0, cnt_add};
    assign cnt_sat = cnt_raw[CW] ? {CW{1'b1}} : cnt_raw[CW-1:0];

    assign v_lt = (in_item.item_value < val_reg);
    assign v_gt = (in_item.item_value > val_reg);

    // Slot update for the presented item
    always_comb
    begin
        val_next  = val_reg;
        cnt_next  = cnt_reg;
        null_next = null_reg;
        unique case (in_item.op)
            spa_pkg::OP_ACC:
            begin
                if (!in_item.item_null)
                begin
                    unique case (kind_reg) inside
                        spa_pkg::KIND_COUNT:
                        begin
                            cnt_next  = cnt_sat;
                            null_next = 1'b0;
                        end
                        spa_pkg::KIND_SUM, spa_pkg::KIND_AVG:
                        begin
                            val_next  = sum_sat;
                            cnt_next  = cnt_sat;
                            null_next = 1'b0;
                        end
                        spa_pkg::KIND_MIN:
                        begin
                            if (null_reg || v_lt)
                                val_next = in_item.item_value;
                            null_next = 1'b0;
                        end
                        spa_pkg::KIND_MAX:
                        begin
                            if (null_reg || v_gt)
                                val_next = in_item.item_value;
                            null_next = 1'b0;
                        end
                        default:
                        begin
                            // unsupported kind: row ignored
                        end
                    endcase
                end
            end
            spa_pkg::OP_MERGE:
            begin
                if (!in_item.item_null)
                begin
                    if (null_reg)
                    begin
                        val_next  = in_item.item_value;
                        cnt_next  = in_item.partial_count;
                        null_next = 1'b0;
                    end
                    else
                    begin
                        unique case (kind_reg) inside
                            spa_pkg::KIND_COUNT:
                                cnt_next = cnt_sat;
                            spa_pkg::KIND_SUM, spa_pkg::KIND_AVG:
                            begin
                                val_next = sum_sat;
                                cnt_next = cnt_sat;
                            end
                            spa_pkg::KIND_MIN:
                                if (v_lt)
                                    val_next = in_item.item_value;
                            spa_pkg::KIND_MAX:
                                if (v_gt)
                                    val_next = in_item.item_value;
                            default:
                            begin
                                // unsupported kind: partial ignored
                            end
                        endcase
                    end
                end
            end
            spa_pkg::OP_CLEAR:
            begin
                val_next  = '0;
                cnt_next  = '0;
                null_next = 1'b1;
            end
            default:
            begin
                // finalize leaves the slot unchanged
            end
        endcase
    end

    // AVG finalize on a non-null slot
    assign avg_fin = (in_item.op == spa_pkg::OP_FIN) && (kind_reg == spa_pkg::KIND_AVG)
                     && !null_reg;
    assign sts.need_div = avg_fin && (cnt_reg != '0);
    assign sts.div_done = div_done;

    spa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (val_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Output register: updated state, null result, or the quotient
    always_comb
    begin
        out_next = out_reg;
        if (cmd.div_load)
        begin
            out_next.result_value = div_q;
            out_next.result_count = cnt_reg;
            out_next.result_null  = 1'b0;
        end
        else if (cmd.accept)
        begin
            if (null_next || avg_fin)
            begin
                out_next.result_value = '0;
                out_next.result_count = '0;
                out_next.result_null  = 1'b1;
            end
            else
            begin
                out_next.result_value = val_next;
                out_next.result_count = cnt_next;
                out_next.result_null  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= spa_pkg::KIND_COUNT;
            val_reg  <= '0;
            cnt_reg  <= '0;
            null_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
                kind_reg <= cfg_kind;
            if (cmd.accept)
            begin
                val_reg  <= val_next;
                cnt_reg  <= cnt_next;
                null_reg <= null_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_item = out_reg;

endmodule

// File: src/spa_ctrl.sv
// Handshake and sequencing state machine for the aggregator.
module spa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  spa_pkg::spa_sts_t  sts,
    output spa_pkg::spa_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DIV  = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic in_fire;

    // Take an item when idle and the output register is empty or frees up this cycle
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    assign cmd.accept    = in_fire;
    assign cmd.div_start = in_fire && sts.need_div;
    assign cmd.div_load  = (state_reg == S_DIV) && sts.div_done;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_fire && sts.need_div)
                    state_next = S_DIV;
            S_DIV:
                if (sts.div_done)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Output item valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((in_fire && !sts.need_div) || cmd.div_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: src/sql_partial_aggregator.sv
// Top level of the SQL partial aggregator (COUNT/SUM/AVG/MIN/MAX slot).
//
//  Channel | Signals                          | Direction | Contents
//  --------+----------------------------------+-----------+---------------------------
//  in      | in_valid, in_ready, in_item      | input     | op, value, null, count
//  out     | out_valid, out_ready, out_item   | output    | result value, count, null
//  cfg     | cfg_valid, cfg_ready, cfg_data   | input     | aggregate kind
//
// Accumulate, merge, clear and divide-free finalize items may follow back to back;
// the result sits in an output register in the cycle after the item is accepted.
// An AVG finalize on a non-null slot with nonzero count runs the bit-serial
// divider, one quotient bit per cycle, and takes no new item until it is done.
// Reset (rst_n, asynchronous) empties the slot to null and sets the kind to COUNT.
// A stalled output holds off new items only while its register is still full.
module sql_partial_aggregator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  spa_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output spa_pkg::out_item_t            out_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [spa_pkg::KIND_W-1:0]    cfg_data
);

    spa_pkg::spa_cmd_t cmd;
    spa_pkg::spa_sts_t sts;

    // Kind register accepts a write every cycle
    assign cfg_ready = 1'b1;

    spa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    spa_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_kind (cfg_data),
        .in_item  (in_item),
        .cmd      (cmd),
        .sts      (sts),
        .out_item (out_item)
    );

endmodule
